// ----- src/b2da_pkg.sv -----
// Shared types and constants for the binary to decimal ASCII unit.
// Used by b2da_dabble and binary_to_decimal_ascii_unit; no dependencies.
package b2da_pkg;

   localparam int DEFAULT_VALUE_BITS = 31;
   localparam logic [5:0] ASCII_ZERO = 6'd48;

   // Control sequencer states of the top level.
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CONVERT,
      ST_EMIT
   } state_type;

   // Commands from the sequencer to the converter.
   typedef struct packed {
      logic start;
      logic shift_digit;
   } conv_ctrl_type;

   // Decimal digits needed for the largest value of the given bit width.
   // 30103 / 100000 approximates log10(2) closely enough up to 64 bits.
   function automatic int num_digits(input int bits);
      return (bits * 30103) / 100000 + 1;
   endfunction

endpackage

// ----- src/binary_to_decimal_ascii_unit.sv -----
// Channel  Direction  Ports                          Moves
// req      in         req_valid/ready, req_value     one unsigned binary item
// rsp      out        rsp_valid/ready, digit, last   one ASCII digit per item
//
// An item is accepted, shifted through the bit-serial converter one input bit
// at a time, handed over, then emitted one decimal digit position at a time
// (leading zero positions are skipped).
// Reset is synchronous and clears only control state. A stalled rsp channel
// holds the sequencer; the next item is taken while the last digit waits.
// Depends on b2da_pkg and b2da_dabble.
module binary_to_decimal_ascii_unit #(
   parameter int VALUE_BITS = b2da_pkg::DEFAULT_VALUE_BITS
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [VALUE_BITS-1:0] req_value,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [5:0]            rsp_digit_char,
   output logic                  rsp_last
);
   import b2da_pkg::*;

   localparam int NUM_DIGITS = num_digits(VALUE_BITS);
   localparam int RW = $clog2(NUM_DIGITS + 1);

   state_type     state_ff, state_in;
   logic [RW-1:0] remain_ff, remain_in;
   logic          seen_ff, seen_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [5:0]    digit_ff, digit_in;
   logic          last_ff, last_in;

   conv_ctrl_type ctrl;
   logic          conv_busy;
   logic [3:0]    top_digit;
   logic          out_free, is_skip, emit;

   b2da_dabble #(
      .VALUE_BITS(VALUE_BITS)
   ) u_dabble (
      .clock    (clock),
      .reset    (reset),
      .ctrl     (ctrl),
      .value    (req_value),
      .busy     (conv_busy),
      .top_digit(top_digit)
   );

   assign out_free = !rsp_valid_ff || rsp_ready;
   // A zero in front of the first nonzero digit is dropped, except the units digit.
   assign is_skip  = (top_digit == 4'd0) && !seen_ff && (remain_ff > RW'(1));

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_CONVERT;
         end
         ST_CONVERT: begin
            if (!conv_busy) state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (emit && remain_ff == RW'(1)) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Sequencer outputs.
   always_comb begin
      req_ready        = 1'b0;
      emit             = 1'b0;
      ctrl.start       = 1'b0;
      ctrl.shift_digit = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready  = 1'b1;
            ctrl.start = req_valid;
         end
         ST_EMIT: begin
            emit             = out_free && !is_skip;
            ctrl.shift_digit = is_skip || emit;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

   always_comb begin
      remain_in    = remain_ff;
      seen_in      = seen_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      digit_in     = digit_ff;
      last_in      = last_ff;
      if (ctrl.start) begin
         remain_in = RW'(NUM_DIGITS);
         seen_in   = 1'b0;
      end else if (ctrl.shift_digit) begin
         remain_in = remain_ff - RW'(1);
      end
      if (emit) begin
         seen_in      = 1'b1;
         rsp_valid_in = 1'b1;
         digit_in     = ASCII_ZERO + {2'b00, top_digit};
         last_in      = (remain_ff == RW'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         remain_ff    <= '0;
         seen_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         remain_ff    <= remain_in;
         seen_ff      <= seen_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      digit_ff <= digit_in;
      last_ff  <= last_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_digit_char = digit_ff;
   assign rsp_last       = last_ff;

`ifndef ASSERT_OFF
   a_idle_conv_quiet: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> !conv_busy)
      else $error("converter busy while sequencer idle");

   a_emit_has_digits: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT) |-> (remain_ff != '0))
      else $error("emit state with no digit positions left");

   a_last_ends_run: assert property (@(posedge clock) disable iff (reset)
      (emit && remain_ff == RW'(1)) |=> (state_ff == ST_IDLE && rsp_last))
      else $error("last digit did not end the run");

   a_digit_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_digit_char >= 6'd48 && rsp_digit_char <= 6'd57))
      else $error("output character is not a decimal digit");
`endif

endmodule

// ----- src/b2da_dabble.sv -----
// Bit-serial shift-and-add-3 converter from binary to packed BCD digits.
// Depends on b2da_pkg; one input bit enters the BCD register per cycle.
module b2da_dabble #(
   parameter int VALUE_BITS = b2da_pkg::DEFAULT_VALUE_BITS
) (
   input  logic                    clock,
   input  logic                    reset,
   input  b2da_pkg::conv_ctrl_type ctrl,
   input  logic [VALUE_BITS-1:0]   value,
   output logic                    busy,
   output logic [3:0]              top_digit
);
   import b2da_pkg::*;

   localparam int NUM_DIGITS = num_digits(VALUE_BITS);
   localparam int CW = $clog2(VALUE_BITS + 1);

   logic [VALUE_BITS-1:0]      bin_ff, bin_in;
   logic [NUM_DIGITS-1:0][3:0] bcd_ff, bcd_in;
   logic [NUM_DIGITS-1:0][3:0] bcd_adj;
   logic [CW-1:0]              count_ff, count_in;

   assign busy      = (count_ff != '0);
   assign top_digit = bcd_ff[NUM_DIGITS-1];

   // Each digit is corrected on its own before the whole register shifts.
   always_comb begin
      for (int i = 0; i < NUM_DIGITS; i++) begin
         bcd_adj[i] = (bcd_ff[i] >= 4'd5) ? bcd_ff[i] + 4'd3 : bcd_ff[i];
      end
   end

   always_comb begin
      bin_in   = bin_ff;
      bcd_in   = bcd_ff;
      count_in = count_ff;
      if (ctrl.start) begin
         bin_in   = value;
         bcd_in   = '0;
         count_in = CW'(VALUE_BITS);
      end else if (busy) begin
         bin_in   = {bin_ff[VALUE_BITS-2:0], 1'b0};
         bcd_in   = (4 * NUM_DIGITS)'({bcd_adj, bin_ff[VALUE_BITS-1]});
         count_in = count_ff - CW'(1);
      end else if (ctrl.shift_digit) begin
         bcd_in = {bcd_ff[NUM_DIGITS-2:0], 4'd0};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      bin_ff <= bin_in;
      bcd_ff <= bcd_in;
   end

endmodule

// ----- test/testbench.sv -----
// Self-checking testbench for binary_to_decimal_ascii_unit.
// Holds its own decimal digit predictor and checks every ASCII digit item.
// Depends on b2da_pkg and the unit's RTL only.
`timescale 1ns / 100ps

module testbench;
   import b2da_pkg::*;

   localparam int VALUE_BITS = DEFAULT_VALUE_BITS;
   localparam int RADIX = 10;
   localparam int MAX_DIGITS = 20;
   localparam int MAX_GAP = 6;
   localparam int DRAIN_CYCLES = 60;
   localparam int IDLE_LIMIT = 1000;

   typedef struct packed {
      logic [5:0] digit_char;
      logic       last;
   } digit_item_type;

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_ready;
   logic [VALUE_BITS-1:0] req_value;
   logic                  rsp_valid;
   logic                  rsp_ready;
   logic [5:0]            rsp_digit_char;
   logic                  rsp_last;

   digit_item_type pending_digits[$];
   int error_count = 0;
   int values_sent = 0;
   int digits_checked = 0;
   bit sender_gaps = 1'b1;
   bit reader_stalls = 1'b1;

   binary_to_decimal_ascii_unit #(
      .VALUE_BITS(VALUE_BITS)
   ) DUT (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_value(req_value),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_digit_char(rsp_digit_char),
      .rsp_last(rsp_last)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Splits a value into decimal digits and queues them most significant first.
   function automatic void predict_digits(input logic [VALUE_BITS-1:0] value);
      logic [63:0] remaining;
      logic [3:0]  digit_stack[MAX_DIGITS];
      int          count;
      digit_item_type item;
      remaining = 64'(value);
      count = 0;
      do begin
         digit_stack[count] = 4'(remaining % RADIX);
         remaining = remaining / RADIX;
         count++;
      end while (remaining != 0 && count < MAX_DIGITS);
      for (int k = count - 1; k >= 0; k--) begin
         item.digit_char = ASCII_ZERO + 6'(digit_stack[k]);
         item.last = (k == 0);
         pending_digits.push_back(item);
      end
   endfunction

   // Picks a decimal length first so that short and long numbers are equally
   // common; now and then a plain random bit pattern of random width instead.
   function automatic logic [VALUE_BITS-1:0] random_value();
      longint unsigned low;
      longint unsigned high;
      longint unsigned top;
      int              length;
      int              width;
      top = (64'd1 << VALUE_BITS) - 1;
      if ($urandom_range(0, 3) == 0) begin
         width = $urandom_range(1, VALUE_BITS);
         return VALUE_BITS'({$urandom, $urandom} & ((64'd1 << width) - 1));
      end
      length = $urandom_range(1, 10);
      low = 1;
      for (int k = 1; k < length; k++) low = low * RADIX;
      high = low * RADIX - 1;
      if (length == 1) low = 0;
      if (high > top) high = top;
      return VALUE_BITS'(low + ({$urandom, $urandom} % (high - low + 1)));
   endfunction

   task automatic report_mismatch(input string message);
      $display("MISMATCH at %0t ns: %s", $time, message);
      error_count++;
   endtask

   task automatic send_value(input logic [VALUE_BITS-1:0] value);
      int gap;
      gap = sender_gaps ? $urandom_range(0, MAX_GAP) : 0;
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         req_value <= VALUE_BITS'({$urandom, $urandom});
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_value <= value;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic test_directed();
      logic [VALUE_BITS-1:0] corner_values[$];
      corner_values = '{0, 1, 7, 9, 10, 11, 99, 100, 101, 999999999, 1000000000,
                        1000000001, 1073741824, 1234567890, 2147483646,
                        {VALUE_BITS{1'b1}}};
      foreach (corner_values[k]) send_value(corner_values[k]);
   endtask

   task automatic test_random_values(input int count);
      sender_gaps = 1'b1;
      reader_stalls = 1'b1;
      repeat (count) send_value(random_value());
   endtask

   task automatic test_back_to_back(input int count);
      sender_gaps = 1'b0;
      reader_stalls = 1'b0;
      repeat (count) send_value(random_value());
   endtask

   task automatic test_slow_reader(input int count);
      sender_gaps = 1'b0;
      reader_stalls = 1'b1;
      repeat (count) send_value(random_value());
   endtask

   task automatic wait_for_drain();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_digits.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Result side: the stall before each item is drawn afresh.
   initial begin
      int stall;
      rsp_ready = 1'b0;
      forever begin
         stall = reader_stalls ? $urandom_range(0, MAX_GAP) : 0;
         @(negedge clock);
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
      end
   end

   // Accepted values feed the predictor; accepted digits are checked in order.
   always @(posedge clock) begin : digit_monitor
      digit_item_type wanted;
      if (!reset) begin
         if (req_valid && req_ready) begin
            predict_digits(req_value);
            values_sent++;
         end
         if (rsp_valid && rsp_ready) begin
            if (pending_digits.size() == 0) begin
               report_mismatch($sformatf("digit char %0d last %0b with nothing pending",
                                         rsp_digit_char, rsp_last));
            end else begin
               wanted = pending_digits.pop_front();
               if (rsp_digit_char !== wanted.digit_char)
                  report_mismatch($sformatf("digit char %0d, predicted %0d",
                                            rsp_digit_char, wanted.digit_char));
               if (rsp_last !== wanted.last)
                  report_mismatch($sformatf("last %0b, predicted %0b on digit char %0d",
                                            rsp_last, wanted.last, wanted.digit_char));
               digits_checked++;
            end
         end
      end
   end

   // Ends the run if neither channel moves an item for too long.
   initial begin
      int idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < IDLE_LIMIT) begin
         @(posedge clock);
         if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready))
            idle_cycles = 0;
         else
            idle_cycles++;
      end
      $display("Timeout: no item moved for %0d cycles", IDLE_LIMIT);
      $display("binary_to_decimal_ascii_unit regression: fail");
      $finish;
   end

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_value = '0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_directed();
      test_random_values(200);
      test_back_to_back(57);
      test_slow_reader(57);
      wait_for_drain();

      if (pending_digits.size() != 0)
         report_mismatch($sformatf("%0d predicted digits never arrived",
                                   pending_digits.size()));
      $display("Converted %0d values into %0d checked digit characters,", values_sent,
               digits_checked);
      $display("covering zero, all ones, every decimal length, stalls and full rate.");
      if (error_count == 0) begin
         $display("binary_to_decimal_ascii_unit regression: pass");
      end else begin
         $display("binary_to_decimal_ascii_unit regression: fail");
      end
      $finish;
   end

endmodule
